// ----- sv/ppc64_fixed_point_unit_top_macros.svh -----
// ----------------------------------------------------------------------------
// Fixed-point unit assertion macros
// Shared concurrent assertion helpers for the fixed-point unit.
// ----------------------------------------------------------------------------
`ifndef PPC64_FIXED_POINT_UNIT_TOP_MACROS_SVH
`define PPC64_FIXED_POINT_UNIT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FXU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FXU_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define FXU_ASSERT(lbl, clk, rstn, prop, msg)
`define FXU_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ----- sv/fxu_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed-point unit package
// Operation codes, the decoded instruction word and shared helpers.
// ----------------------------------------------------------------------------
package fxu_pkg;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADDI = 6'd1, OP_ADDIC = 6'd2, OP_ADDIC_RC = 6'd3,
    OP_ADDIS = 6'd4, OP_AND = 6'd5, OP_ANDC = 6'd6, OP_ANDI = 6'd7,
    OP_ANDIS = 6'd8, OP_CMP = 6'd9, OP_CMPI = 6'd10, OP_CMPL = 6'd11,
    OP_CMPLI = 6'd12, OP_CNTLZW = 6'd13, OP_DIVDU = 6'd14, OP_EXTSB = 6'd15,
    OP_EXTSH = 6'd16, OP_EXTSW = 6'd17, OP_MFCR = 6'd18, OP_MTCRF = 6'd19,
    OP_MULLI = 6'd20, OP_MULLD = 6'd21, OP_MULLW = 6'd22, OP_MULHDU = 6'd23,
    OP_NEG = 6'd24, OP_NOR = 6'd25, OP_ORI = 6'd26, OP_ORIS = 6'd27,
    OP_OR = 6'd28, OP_RLDIC = 6'd29, OP_RLDCR = 6'd30, OP_RLDICL = 6'd31,
    OP_RLDICR = 6'd32, OP_RLDIMI = 6'd33, OP_RLWIMI = 6'd34, OP_RLWNM = 6'd35,
    OP_RLWINM = 6'd36, OP_SLD = 6'd37, OP_SLW = 6'd38, OP_SRAD = 6'd39,
    OP_SRADI = 6'd40, OP_SRAWI = 6'd41, OP_SRD = 6'd42, OP_SRW = 6'd43,
    OP_SUBFC = 6'd44, OP_SUBF = 6'd45, OP_SUBFE = 6'd46, OP_SUBFIC = 6'd47,
    OP_XORI = 6'd48, OP_XORIS = 6'd49, OP_XOR = 6'd50
  } op_e;

  // Highest defined operation code; codes above it do nothing.
  localparam logic [5:0] OpLast = 6'd50;
  localparam int unsigned QueueDepth = 2;

  // One classified instruction as it crosses from front to back.
  typedef struct packed {
    logic [5:0]  action;
    logic        valid_op;
    logic [4:0]  dest_index;
    logic [4:0]  src_a_index;
    logic [4:0]  src_b_index;
    logic [15:0] immediate;
    logic [5:0]  shift_amount;
    logic [5:0]  mask_begin;
    logic [5:0]  mask_end;
    logic [2:0]  cr_field;
    logic        long_compare;
    logic        record;
    logic [7:0]  field_mask;
  } instr_t;

  // Mask from big-endian bit b to bit e, wrapping when b > e.
  function automatic logic [63:0] mask64(input logic [5:0] b, input logic [5:0] e);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = {64{1'b1}} >> b;
    lo = {64{1'b1}} << (6'd63 - e);
    return (b <= e) ? (hi & lo) : (hi | lo);
  endfunction

endpackage

// ----- sv/fxu_front.sv -----
// ----------------------------------------------------------------------------
// Fixed-point unit front end
// Accepts instruction words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module fxu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [5:0]         action_i,
  input  logic [4:0]         dest_index_i,
  input  logic [4:0]         src_a_index_i,
  input  logic [4:0]         src_b_index_i,
  input  logic [15:0]        immediate_i,
  input  logic [5:0]         shift_amount_i,
  input  logic [5:0]         mask_begin_i,
  input  logic [5:0]         mask_end_i,
  input  logic [2:0]         cr_field_i,
  input  logic               long_compare_i,
  input  logic               record_i,
  input  logic [7:0]         field_mask_i,
  output logic               q_valid_o,
  output fxu_pkg::instr_t    q_instr_o,
  input  logic               q_take_i
);

  fxu_pkg::instr_t entry_q [fxu_pkg::QueueDepth];
  logic            wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_push, do_pop;
  fxu_pkg::instr_t incoming;

  assign full      = (cnt_q == 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = q_take_i && q_valid_o;
  assign q_instr_o = entry_q[rd_ptr_q];

  always_comb begin
    incoming.action       = action_i;
    incoming.valid_op     = (action_i <= fxu_pkg::OpLast);
    incoming.dest_index   = dest_index_i;
    incoming.src_a_index  = src_a_index_i;
    incoming.src_b_index  = src_b_index_i;
    incoming.immediate    = immediate_i;
    incoming.shift_amount = shift_amount_i;
    incoming.mask_begin   = mask_begin_i;
    incoming.mask_end     = mask_end_i;
    incoming.cr_field     = cr_field_i;
    incoming.long_compare = long_compare_i;
    incoming.record       = record_i;
    incoming.field_mask   = field_mask_i;
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= incoming;
    end
  end

endmodule

// ----- sv/fxu_back.sv -----
// ----------------------------------------------------------------------------
// Fixed-point unit back end
// Reads operands, executes one instruction and holds the result word.
// ----------------------------------------------------------------------------
`include "ppc64_fixed_point_unit_top_macros.svh"
module fxu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  fxu_pkg::instr_t    q_instr_i,
  output logic               q_take_o,
  output logic               empty,
  input  logic               pop,
  output logic [63:0]        result_value_o,
  output logic [4:0]         result_index_o,
  output logic               register_written_o,
  output logic [31:0]        condition_register_o,
  output logic               carry_bit_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_MULH, ST_DIV, ST_COMMIT, ST_OUT
  } state_e;

  state_e          state_q;
  fxu_pkg::instr_t ins_q;
  logic [63:0]     rf_q [32];
  logic [31:0]     cr_q;
  logic            ca_q;
  logic [63:0]     a_q, b_q, d_q;
  logic            a_zero_q;
  logic [63:0]     val_q, val_d;
  logic            wr_q, wr_d, rec_q, rec_d, ca_d;
  logic [31:0]     cr_d;
  logic [6:0]      cnt_q;
  logic [63:0]     quo_q, rem_q;
  logic [64:0]     rem_try;
  logic [63:0]     p00_q, p01_q, p10_q, p11_q;
  logic [63:0]     mid;
  logic [63:0]     mul_b;
  logic [63:0]     mul_lo;
  logic [3:0]      cr0;

  // Operand views used by the execute step.
  logic [63:0] si, rot, wrot, m, mw, shl, sro;
  logic [64:0] sum;
  logic [5:0]  rsh;
  logic [4:0]  wsh;
  logic [3:0]  cmpnib;
  logic [63:0] ca_, cb_;
  logic        sgn_cmp;
  logic [31:0] fm;
  logic [5:0]  lz;
  logic [6:0]  srn;
  logic [63:0] sra_v;
  logic        sra_ca;
  logic [63:0] sra_in;

  assign q_take_o = (state_q == ST_IDLE) && q_valid_i;
  assign empty    = (state_q != ST_OUT);

  // Second multiplier operand: the sign-extended immediate for mulli.
  assign mul_b  = (ins_q.action == fxu_pkg::OP_MULLI) ? si : b_q;
  // Low 64 bits of the full product, built from the 32-bit partial products.
  assign mul_lo = p00_q + {p01_q[31:0] + p10_q[31:0], 32'd0};

  function automatic logic [3:0] cmp_u(input logic [63:0] x, input logic [63:0] y);
    return (x < y) ? 4'h8 : ((x > y) ? 4'h4 : 4'h2);
  endfunction

  always_comb begin
    si   = {{48{ins_q.immediate[15]}}, ins_q.immediate};
    rsh  = (ins_q.action == fxu_pkg::OP_RLDCR) ? b_q[5:0] : ins_q.shift_amount;
    rot  = (a_q << rsh) | (a_q >> (7'd64 - {1'b0, rsh}));
    wsh  = (ins_q.action == fxu_pkg::OP_RLWNM) ? b_q[4:0] : ins_q.shift_amount[4:0];
    wrot = {2{(a_q[31:0] << wsh) | (a_q[31:0] >> (6'd32 - {1'b0, wsh}))}};
    mw   = fxu_pkg::mask64({1'b1, ins_q.mask_begin[4:0]}, {1'b1, ins_q.mask_end[4:0]});
    m    = 64'd0;
    unique case (ins_q.action)
      fxu_pkg::OP_RLDIC, fxu_pkg::OP_RLDIMI:
        m = fxu_pkg::mask64(ins_q.mask_begin, 6'd63 - ins_q.shift_amount);
      fxu_pkg::OP_RLDCR, fxu_pkg::OP_RLDICR: m = fxu_pkg::mask64(6'd0, ins_q.mask_end);
      default: m = fxu_pkg::mask64(ins_q.mask_begin, 6'd63);
    endcase
    shl = a_q << b_q[5:0];
    sro = a_q >> b_q[5:0];
    // Compare operands.
    ca_ = a_q;
    cb_ = b_q;
    sgn_cmp = 1'b1;
    unique case (ins_q.action)
      fxu_pkg::OP_CMP: if (!ins_q.long_compare) begin
        ca_ = {{32{a_q[31]}}, a_q[31:0]};
        cb_ = {{32{b_q[31]}}, b_q[31:0]};
      end
      fxu_pkg::OP_CMPI: begin
        cb_ = si;
        if (!ins_q.long_compare) ca_ = {{32{a_q[31]}}, a_q[31:0]};
      end
      fxu_pkg::OP_CMPL: begin
        sgn_cmp = 1'b0;
        if (!ins_q.long_compare) begin
          ca_ = {32'd0, a_q[31:0]};
          cb_ = {32'd0, b_q[31:0]};
        end
      end
      fxu_pkg::OP_CMPLI: begin
        sgn_cmp = 1'b0;
        cb_ = {48'd0, ins_q.immediate};
        if (!ins_q.long_compare) ca_ = {32'd0, a_q[31:0]};
      end
      default: ;
    endcase
    cmpnib = cmp_u({ca_[63] ^ sgn_cmp, ca_[62:0]}, {cb_[63] ^ sgn_cmp, cb_[62:0]});
    for (int i = 0; i < 8; i++) begin
      fm[31 - 4*i -: 4] = {4{ins_q.field_mask[7 - i]}};
    end
    lz = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (a_q[i]) lz = 6'(31 - i);
    end
    // Arithmetic right shift with carry.
    srn    = {1'b0, ins_q.shift_amount};
    sra_in = a_q;
    if (ins_q.action == fxu_pkg::OP_SRAD) srn = b_q[6:0];
    if (ins_q.action == fxu_pkg::OP_SRAWI) begin
      srn    = {2'b0, ins_q.shift_amount[4:0]};
      sra_in = {{32{a_q[31]}}, a_q[31:0]};
    end
    if (srn[6]) begin
      sra_v  = {64{sra_in[63]}};
      sra_ca = sra_in[63];
    end else begin
      sra_v  = 64'($signed(sra_in) >>> srn[5:0]);
      sra_ca = sra_in[63] && ((sra_in & ~({64{1'b1}} << srn[5:0])) != 64'd0);
    end
  end

  // Execute step: computes the result for every operation but mulhdu and divdu.
  always_comb begin
    val_d = 64'd0;
    wr_d  = 1'b1;
    rec_d = ins_q.record;
    ca_d  = ca_q;
    cr_d  = cr_q;
    sum   = 65'd0;
    unique case (ins_q.action)
      fxu_pkg::OP_ADD:   val_d = a_q + b_q;
      fxu_pkg::OP_ADDI:  begin val_d = (a_zero_q ? 64'd0 : a_q) + si; rec_d = 1'b0; end
      fxu_pkg::OP_ADDIC, fxu_pkg::OP_ADDIC_RC: begin
        sum = {1'b0, a_q} + {1'b0, si};
        val_d = sum[63:0];
        ca_d = sum[64];
        rec_d = (ins_q.action == fxu_pkg::OP_ADDIC_RC);
      end
      fxu_pkg::OP_ADDIS: begin
        val_d = (a_zero_q ? 64'd0 : a_q) + (si << 16);
        rec_d = 1'b0;
      end
      fxu_pkg::OP_AND:   val_d = a_q & b_q;
      fxu_pkg::OP_ANDC:  val_d = a_q & ~b_q;
      fxu_pkg::OP_ANDI:  begin val_d = a_q & {48'd0, ins_q.immediate}; rec_d = 1'b1; end
      fxu_pkg::OP_ANDIS: begin
        val_d = a_q & {32'd0, ins_q.immediate, 16'd0};
        rec_d = 1'b1;
      end
      fxu_pkg::OP_CMP, fxu_pkg::OP_CMPI, fxu_pkg::OP_CMPL, fxu_pkg::OP_CMPLI: begin
        cr_d[31 - 4*ins_q.cr_field -: 4] = cmpnib;
        wr_d = 1'b0;
        rec_d = 1'b0;
      end
      fxu_pkg::OP_CNTLZW: val_d = {58'd0, lz};
      fxu_pkg::OP_EXTSB: val_d = {{56{a_q[7]}}, a_q[7:0]};
      fxu_pkg::OP_EXTSH: val_d = {{48{a_q[15]}}, a_q[15:0]};
      fxu_pkg::OP_EXTSW: val_d = {{32{a_q[31]}}, a_q[31:0]};
      fxu_pkg::OP_MFCR:  begin val_d = {32'd0, cr_q}; rec_d = 1'b0; end
      fxu_pkg::OP_MTCRF: begin
        cr_d = (a_q[31:0] & fm) | (cr_q & ~fm);
        wr_d = 1'b0;
        rec_d = 1'b0;
      end
      fxu_pkg::OP_MULLI: begin val_d = mul_lo; rec_d = 1'b0; end
      fxu_pkg::OP_MULLD: val_d = mul_lo;
      fxu_pkg::OP_MULLW: val_d = p00_q;
      fxu_pkg::OP_NEG:   val_d = ~a_q + 64'd1;
      fxu_pkg::OP_NOR:   val_d = ~(a_q | b_q);
      fxu_pkg::OP_ORI:   begin val_d = a_q | {48'd0, ins_q.immediate}; rec_d = 1'b0; end
      fxu_pkg::OP_ORIS:  begin
        val_d = a_q | {32'd0, ins_q.immediate, 16'd0};
        rec_d = 1'b0;
      end
      fxu_pkg::OP_OR:    val_d = a_q | b_q;
      fxu_pkg::OP_RLDIC, fxu_pkg::OP_RLDCR, fxu_pkg::OP_RLDICL, fxu_pkg::OP_RLDICR:
        val_d = rot & m;
      fxu_pkg::OP_RLDIMI: val_d = (rot & m) | (d_q & ~m);
      fxu_pkg::OP_RLWIMI: val_d = (wrot & mw) | (d_q & ~mw);
      fxu_pkg::OP_RLWNM, fxu_pkg::OP_RLWINM: val_d = wrot & mw;
      fxu_pkg::OP_SLD:   val_d = b_q[6] ? 64'd0 : shl;
      fxu_pkg::OP_SLW:   val_d = b_q[5] ? 64'd0 : {32'd0, shl[31:0]};
      fxu_pkg::OP_SRAD, fxu_pkg::OP_SRADI, fxu_pkg::OP_SRAWI: begin
        val_d = sra_v;
        ca_d = sra_ca;
      end
      fxu_pkg::OP_SRD:   val_d = b_q[6] ? 64'd0 : sro;
      fxu_pkg::OP_SRW:   val_d = b_q[5] ? 64'd0 : {32'd0, a_q[31:0] >> b_q[4:0]};
      fxu_pkg::OP_SUBFC, fxu_pkg::OP_SUBFE: begin
        sum = {1'b0, ~a_q} + {1'b0, b_q}
            + {64'd0, (ins_q.action == fxu_pkg::OP_SUBFC) ? 1'b1 : ca_q};
        val_d = sum[63:0];
        ca_d = sum[64];
      end
      fxu_pkg::OP_SUBF:  val_d = ~a_q + b_q + 64'd1;
      fxu_pkg::OP_SUBFIC: begin
        sum = {1'b0, ~a_q} + {1'b0, si} + 65'd1;
        val_d = sum[63:0];
        ca_d = sum[64];
        rec_d = 1'b0;
      end
      fxu_pkg::OP_XORI:  begin val_d = a_q ^ {48'd0, ins_q.immediate}; rec_d = 1'b0; end
      fxu_pkg::OP_XORIS: begin
        val_d = a_q ^ {32'd0, ins_q.immediate, 16'd0};
        rec_d = 1'b0;
      end
      fxu_pkg::OP_XOR:   val_d = a_q ^ b_q;
      default: begin wr_d = 1'b0; rec_d = 1'b0; end
    endcase
    mid     = {32'd0, p00_q[63:32]} + {32'd0, p01_q[31:0]} + {32'd0, p10_q[31:0]};
    rem_try = {rem_q, quo_q[63]} - {1'b0, b_q};
    cr0     = val_q[63] ? 4'h8 : ((val_q != 64'd0) ? 4'h4 : 4'h2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cr_q    <= 32'd0;
      ca_q    <= 1'b0;
      wr_q    <= 1'b0;
      rec_q   <= 1'b0;
      cnt_q   <= 7'd0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (q_valid_i) state_q <= ST_READ;
        ST_READ: begin
          if (ins_q.action == fxu_pkg::OP_DIVDU) begin
            cnt_q   <= 7'd64;
            state_q <= ST_DIV;
          end else if (ins_q.action inside {fxu_pkg::OP_MULLI, fxu_pkg::OP_MULLD,
                                            fxu_pkg::OP_MULLW, fxu_pkg::OP_MULHDU}) begin
            state_q <= ST_MUL;
          end else begin
            state_q <= ST_EXEC;
          end
        end
        // The partial products load from the fresh operands here.
        ST_MUL: begin
          if (ins_q.action == fxu_pkg::OP_MULHDU) begin
            state_q <= ST_MULH;
          end else begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          wr_q <= wr_d;
          rec_q <= rec_d;
          cr_q <= cr_d;
          ca_q <= ca_d;
          state_q <= ST_COMMIT;
        end
        ST_MULH: begin
          wr_q <= 1'b1;
          rec_q <= ins_q.record;
          state_q <= ST_COMMIT;
        end
        ST_DIV: begin
          if (cnt_q == 7'd0) begin
            wr_q <= (b_q != 64'd0);
            rec_q <= ins_q.record;
            state_q <= ST_COMMIT;
          end else begin
            cnt_q <= cnt_q - 7'd1;
          end
        end
        ST_COMMIT: begin
          if (rec_q) cr_q[31:28] <= cr0;
          state_q <= ST_OUT;
        end
        ST_OUT: if (pop) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The register file, reset to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) rf_q[i] <= 64'd0;
    end else if (state_q == ST_COMMIT && wr_q) begin
      rf_q[ins_q.dest_index] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_take_o) ins_q <= q_instr_i;
    if (state_q == ST_READ) begin
      a_q      <= rf_q[ins_q.src_a_index];
      b_q      <= rf_q[ins_q.src_b_index];
      d_q      <= rf_q[ins_q.dest_index];
      a_zero_q <= (ins_q.src_a_index == 5'd0);
      quo_q    <= rf_q[ins_q.src_a_index];
      rem_q    <= 64'd0;
    end
    if (state_q == ST_EXEC) val_q <= val_d;
    if (state_q == ST_MULH)
      val_q <= p11_q + {32'd0, p01_q[63:32]} + {32'd0, p10_q[63:32]} + {32'd0, mid[63:32]};
    if (state_q == ST_DIV) begin
      if (cnt_q == 7'd0) begin
        val_q <= (b_q != 64'd0) ? quo_q : d_q;
      end else if (!rem_try[64]) begin
        rem_q <= rem_try[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= {rem_q[62:0], quo_q[63]};
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  // Multiplier partial products, 32 by 32 bits each, registered from the
  // operands that the read step loaded.
  always_ff @(posedge clk_i) begin
    if (ins_q.action == fxu_pkg::OP_MULLW) begin
      p00_q <= 64'($signed(a_q[31:0]) * $signed(b_q[31:0]));
    end else begin
      p00_q <= {32'd0, a_q[31:0]} * {32'd0, mul_b[31:0]};
    end
    p01_q <= {32'd0, a_q[31:0]} * {32'd0, mul_b[63:32]};
    p10_q <= {32'd0, a_q[63:32]} * {32'd0, mul_b[31:0]};
    p11_q <= {32'd0, a_q[63:32]} * {32'd0, mul_b[63:32]};
  end

  assign result_value_o       = wr_q ? val_q : 64'd0;
  assign result_index_o       = wr_q ? ins_q.dest_index : 5'd0;
  assign register_written_o   = wr_q;
  assign condition_register_o = cr_q;
  assign carry_bit_o          = ca_q;

  `FXU_ASSERT(a_take_idle, clk_i, rst_ni, q_take_o |=> state_q == ST_READ, "take without read")
  `FXU_ASSERT(a_out_hold, clk_i, rst_ni, (!empty && !pop) |=> !empty, "result dropped")
  `FXU_ASSERT_NEVER(a_div_cnt, clk_i, rst_ni, state_q == ST_DIV && cnt_q > 7'd64, "divide count")

endmodule

// ----- sv/ppc64_fixed_point_unit_top.sv -----
// ----------------------------------------------------------------------------
// PowerPC 64-bit fixed-point unit
// Integer execution unit with register file, condition register and carry.
// ----------------------------------------------------------------------------
// A word pushed into the unit carries one decoded integer instruction. The
// front end queues up to two words; the back end executes one at a time and
// holds its result word until it is popped. Most instructions pass through
// the steps take, operand read, execute, writeback and output, from the
// word being taken off the queue to its result being shown. The multiplies
// pass through a partial-product step as well, because the 32-bit partial
// products are registered before they are summed, and divdu replaces execute
// with the bit-serial divider, which retires one quotient bit per cycle and
// then picks the result. The next word starts only once the previous result
// has been popped, since each instruction may read what the one before it
// wrote. A divide by zero leaves the target register unchanged.
module ppc64_fixed_point_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [5:0]  action_i,
  input  logic [4:0]  dest_index_i,
  input  logic [4:0]  src_a_index_i,
  input  logic [4:0]  src_b_index_i,
  input  logic [15:0] immediate_i,
  input  logic [5:0]  shift_amount_i,
  input  logic [5:0]  mask_begin_i,
  input  logic [5:0]  mask_end_i,
  input  logic [2:0]  cr_field_i,
  input  logic        long_compare_i,
  input  logic        record_i,
  input  logic [7:0]  field_mask_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] result_value_o,
  output logic [4:0]  result_index_o,
  output logic        register_written_o,
  output logic [31:0] condition_register_o,
  output logic        carry_bit_o
);

  logic            q_valid;
  logic            q_take;
  fxu_pkg::instr_t q_instr;

  fxu_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .action_i, .dest_index_i, .src_a_index_i, .src_b_index_i, .immediate_i,
    .shift_amount_i, .mask_begin_i, .mask_end_i, .cr_field_i, .long_compare_i,
    .record_i, .field_mask_i,
    .q_valid_o(q_valid), .q_instr_o(q_instr), .q_take_i(q_take)
  );

  fxu_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_instr_i(q_instr), .q_take_o(q_take),
    .empty, .pop,
    .result_value_o, .result_index_o, .register_written_o,
    .condition_register_o, .carry_bit_o
  );

endmodule

// ----- tb/tb_ppc64_fixed_point_unit_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point unit testbench
// Pushes decoded integer instructions into the unit and pops its result
// words at random rates. Every popped word is compared with a software copy
// of the unit that tracks the register file, condition register and carry.
// ----------------------------------------------------------------------------
module tb_ppc64_fixed_point_unit_top;

  // One decoded instruction as pushed into the unit.
  typedef struct {
    logic [5:0]  action;
    logic [4:0]  dest_index;
    logic [4:0]  src_a_index;
    logic [4:0]  src_b_index;
    logic [15:0] immediate;
    logic [5:0]  shift_amount;
    logic [5:0]  mask_begin;
    logic [5:0]  mask_end;
    logic [2:0]  cr_field;
    logic        long_compare;
    logic        record;
    logic [7:0]  field_mask;
  } instr_word_t;

  // One result word as popped from the unit.
  typedef struct {
    logic [63:0] value;
    logic [4:0]  index;
    logic        written;
    logic [31:0] cr;
    logic        carry;
  } result_word_t;

  // The scoreboard holds a copy of the architectural state. Because the unit
  // executes strictly in order, the expected result of each instruction can
  // be computed the moment it is pushed.
  class fxu_scoreboard;
    logic [63:0]  gpr [32];
    logic [31:0]  cr;
    logic         ca;
    result_word_t pending_results [$];
    int           mismatches;

    function void clear_state();
      foreach (gpr[i]) gpr[i] = '0;
      cr = '0;
      ca = 1'b0;
      mismatches = 0;
    endfunction

    function logic [63:0] sext(logic [63:0] v, int bits);
      logic [63:0] m;
      m = 64'd1 << (bits - 1);
      return (v & ((m << 1) - 1) ^ m) - m;
    endfunction

    function logic [63:0] rotl(logic [63:0] v, logic [5:0] n);
      return (n == 0) ? v : ((v << n) | (v >> (7'd64 - n)));
    endfunction

    function logic [63:0] ones_mask(logic [5:0] b, logic [5:0] e);
      logic [63:0] hi;
      logic [63:0] lo;
      hi = {64{1'b1}} >> b;
      lo = {64{1'b1}} << (63 - e);
      return (b <= e) ? (hi & lo) : (hi | lo);
    endfunction

    function logic [63:0] wrot(logic [63:0] v, logic [4:0] n);
      logic [31:0] w;
      w = v[31:0];
      if (n != 0) w = (w << n) | (w >> (32 - n));
      return {w, w};
    endfunction

    function logic [63:0] wmask(logic [5:0] mb, logic [5:0] me);
      return ones_mask({1'b1, mb[4:0]}, {1'b1, me[4:0]});
    endfunction

    function logic [3:0] cmpu(logic [63:0] a, logic [63:0] b);
      return (a < b) ? 4'h8 : ((a > b) ? 4'h4 : 4'h2);
    endfunction

    function logic [3:0] cmps(logic [63:0] a, logic [63:0] b);
      return cmpu({~a[63], a[62:0]}, {~b[63], b[62:0]});
    endfunction

    function void put_field(logic [2:0] f, logic [3:0] nib);
      cr[31 - 4 * f -: 4] = nib;
    endfunction

    function logic [63:0] add_ca(logic [63:0] a, logic [63:0] b, logic c);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b} + c;
      ca = s[64];
      return s[63:0];
    endfunction

    function logic [63:0] sra_ca(logic [63:0] v, int n);
      logic [63:0] low;
      if (n >= 64) begin
        ca = v[63];
        return {64{v[63]}};
      end
      low = (n == 0) ? 64'd0 : ({64{1'b1}} >> (64 - n));
      ca = v[63] && n != 0 && (v & low) != 0;
      return $signed(v) >>> n;
    endfunction

    // Executes one instruction against the copy and queues its result word.
    function void note_instr(instr_word_t w);
      logic [63:0]  a, b, si, val, m;
      logic [127:0] wide;
      logic [31:0]  fm;
      logic         wr, rec;
      int           n;
      result_word_t r;
      a = gpr[w.src_a_index];
      b = gpr[w.src_b_index];
      si = sext({48'd0, w.immediate}, 16);
      val = '0;
      wr = 1'b1;
      rec = w.record;
      case (w.action)
        fxu_pkg::OP_ADD:      val = a + b;
        fxu_pkg::OP_ADDI:     begin val = ((w.src_a_index != 0) ? a : 0) + si; rec = 0; end
        fxu_pkg::OP_ADDIC:    begin val = add_ca(a, si, 0); rec = 0; end
        fxu_pkg::OP_ADDIC_RC: begin val = add_ca(a, si, 0); rec = 1; end
        fxu_pkg::OP_ADDIS: begin
          val = ((w.src_a_index != 0) ? a : 0) + (si << 16);
          rec = 0;
        end
        fxu_pkg::OP_AND:      val = a & b;
        fxu_pkg::OP_ANDC:     val = a & ~b;
        fxu_pkg::OP_ANDI:     begin val = a & w.immediate; rec = 1; end
        fxu_pkg::OP_ANDIS:    begin val = a & ({48'd0, w.immediate} << 16); rec = 1; end
        fxu_pkg::OP_CMP: begin
          put_field(w.cr_field, w.long_compare ? cmps(a, b) : cmps(sext(a, 32), sext(b, 32)));
          wr = 0; rec = 0;
        end
        fxu_pkg::OP_CMPI: begin
          put_field(w.cr_field, w.long_compare ? cmps(a, si) : cmps(sext(a, 32), si));
          wr = 0; rec = 0;
        end
        fxu_pkg::OP_CMPL: begin
          put_field(w.cr_field, w.long_compare ? cmpu(a, b) : cmpu(a[31:0], b[31:0]));
          wr = 0; rec = 0;
        end
        fxu_pkg::OP_CMPLI: begin
          put_field(w.cr_field, cmpu(w.long_compare ? a : a[31:0], w.immediate));
          wr = 0; rec = 0;
        end
        fxu_pkg::OP_CNTLZW: begin
          n = 0;
          while (n < 32 && a[31 - n] == 0) n++;
          val = n;
        end
        fxu_pkg::OP_DIVDU: begin
          if (b != 0) val = a / b;
          else begin
            wr = 0;
            val = gpr[w.dest_index];
          end
        end
        fxu_pkg::OP_EXTSB:    val = sext(a, 8);
        fxu_pkg::OP_EXTSH:    val = sext(a, 16);
        fxu_pkg::OP_EXTSW:    val = sext(a, 32);
        fxu_pkg::OP_MFCR:     begin val = cr; rec = 0; end
        fxu_pkg::OP_MTCRF: begin
          for (int i = 0; i < 8; i++) fm[31 - 4 * i -: 4] = {4{w.field_mask[7 - i]}};
          cr = (a[31:0] & fm) | (cr & ~fm);
          wr = 0; rec = 0;
        end
        fxu_pkg::OP_MULLI:    begin val = a * si; rec = 0; end
        fxu_pkg::OP_MULLD:    val = a * b;
        fxu_pkg::OP_MULLW:    val = sext(a, 32) * sext(b, 32);
        fxu_pkg::OP_MULHDU: begin
          wide = {64'd0, a} * {64'd0, b};
          val = wide[127:64];
        end
        fxu_pkg::OP_NEG:      val = ~a + 1;
        fxu_pkg::OP_NOR:      val = ~(a | b);
        fxu_pkg::OP_ORI:      begin val = a | w.immediate; rec = 0; end
        fxu_pkg::OP_ORIS:     begin val = a | ({48'd0, w.immediate} << 16); rec = 0; end
        fxu_pkg::OP_OR:       val = a | b;
        fxu_pkg::OP_RLDIC:
          val = rotl(a, w.shift_amount) & ones_mask(w.mask_begin, 63 - w.shift_amount);
        fxu_pkg::OP_RLDCR:    val = rotl(a, b[5:0]) & ones_mask(0, w.mask_end);
        fxu_pkg::OP_RLDICL:   val = rotl(a, w.shift_amount) & ones_mask(w.mask_begin, 63);
        fxu_pkg::OP_RLDICR:   val = rotl(a, w.shift_amount) & ones_mask(0, w.mask_end);
        fxu_pkg::OP_RLDIMI: begin
          m = ones_mask(w.mask_begin, 63 - w.shift_amount);
          val = (rotl(a, w.shift_amount) & m) | (gpr[w.dest_index] & ~m);
        end
        fxu_pkg::OP_RLWIMI: begin
          m = wmask(w.mask_begin, w.mask_end);
          val = (wrot(a, w.shift_amount[4:0]) & m) | (gpr[w.dest_index] & ~m);
        end
        fxu_pkg::OP_RLWNM:    val = wrot(a, b[4:0]) & wmask(w.mask_begin, w.mask_end);
        fxu_pkg::OP_RLWINM:
          val = wrot(a, w.shift_amount[4:0]) & wmask(w.mask_begin, w.mask_end);
        fxu_pkg::OP_SLD:      val = b[6] ? 0 : (a << b[5:0]);
        fxu_pkg::OP_SLW:      val = (b[5:0] < 32) ? {32'd0, (a << b[5:0]) & 64'hFFFF_FFFF} : 0;
        fxu_pkg::OP_SRAD:     val = sra_ca(a, b[6:0]);
        fxu_pkg::OP_SRADI:    val = sra_ca(a, w.shift_amount);
        fxu_pkg::OP_SRAWI:    val = sra_ca(sext(a, 32), w.shift_amount[4:0]);
        fxu_pkg::OP_SRD:      val = b[6] ? 0 : (a >> b[5:0]);
        fxu_pkg::OP_SRW:      val = (b[5:0] < 32) ? {32'd0, a[31:0] >> b[5:0]} : 0;
        fxu_pkg::OP_SUBFC:    val = add_ca(~a, b, 1);
        fxu_pkg::OP_SUBF:     val = ~a + b + 1;
        fxu_pkg::OP_SUBFE:    val = add_ca(~a, b, ca);
        fxu_pkg::OP_SUBFIC:   begin val = add_ca(~a, si, 1); rec = 0; end
        fxu_pkg::OP_XORI:     begin val = a ^ w.immediate; rec = 0; end
        fxu_pkg::OP_XORIS:    begin val = a ^ ({48'd0, w.immediate} << 16); rec = 0; end
        fxu_pkg::OP_XOR:      val = a ^ b;
        default:              begin wr = 0; rec = 0; end
      endcase
      if (rec) put_field(0, cmps(val, 0));
      if (wr) gpr[w.dest_index] = val;
      r.value = wr ? val : 0;
      r.index = wr ? w.dest_index : 0;
      r.written = wr;
      r.cr = cr;
      r.carry = ca;
      pending_results.push_back(r);
    endfunction

    // Compares one popped result word with the oldest expected one.
    function void check_result(result_word_t got);
      result_word_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, value %h", $realtime, got.value);
        mismatches++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.value !== exp_r.value) begin
        $display("%0t: result_value expected %h actual %h", $realtime, exp_r.value, got.value);
        mismatches++;
      end
      if (got.index !== exp_r.index) begin
        $display("%0t: result_index expected %0d actual %0d", $realtime, exp_r.index, got.index);
        mismatches++;
      end
      if (got.written !== exp_r.written) begin
        $display("%0t: register_written expected %b actual %b", $realtime, exp_r.written,
                 got.written);
        mismatches++;
      end
      if (got.cr !== exp_r.cr) begin
        $display("%0t: condition_register expected %h actual %h", $realtime, exp_r.cr, got.cr);
        mismatches++;
      end
      if (got.carry !== exp_r.carry) begin
        $display("%0t: carry_bit expected %b actual %b", $realtime, exp_r.carry, got.carry);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        empty;
  logic        pop;
  instr_word_t drive_w;
  logic [63:0] result_value_o;
  logic [4:0]  result_index_o;
  logic        register_written_o;
  logic [31:0] condition_register_o;
  logic        carry_bit_o;

  fxu_scoreboard sb;
  bit            stimulus_done;
  bit            hold_off;
  longint        cycle_count;

  localparam longint CycleLimit = 400000;

  ppc64_fixed_point_unit_top DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .action_i            (drive_w.action),
    .dest_index_i        (drive_w.dest_index),
    .src_a_index_i       (drive_w.src_a_index),
    .src_b_index_i       (drive_w.src_b_index),
    .immediate_i         (drive_w.immediate),
    .shift_amount_i      (drive_w.shift_amount),
    .mask_begin_i        (drive_w.mask_begin),
    .mask_end_i          (drive_w.mask_end),
    .cr_field_i          (drive_w.cr_field),
    .long_compare_i      (drive_w.long_compare),
    .record_i            (drive_w.record),
    .field_mask_i        (drive_w.field_mask),
    .empty               (empty),
    .pop                 (pop),
    .result_value_o      (result_value_o),
    .result_index_o      (result_index_o),
    .register_written_o  (register_written_o),
    .condition_register_o(condition_register_o),
    .carry_bit_o         (carry_bit_o)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog: the slowest legal run is far below this, even with every word
  // a divide and every pop delayed by the longest gap.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Random register values lean toward the corners: zero, all ones and the
  // sign boundaries, which is where carries and compares turn over.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return {64{1'b1}};
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return {32'd0, $urandom()};
      5: return {{32{1'b1}}, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic instr_word_t random_instr(logic [5:0] op);
    instr_word_t w;
    w.action       = op;
    w.dest_index   = $urandom_range(0, 31);
    w.src_a_index  = $urandom_range(0, 31);
    w.src_b_index  = $urandom_range(0, 31);
    w.immediate    = $urandom_range(0, 65535);
    w.shift_amount = $urandom_range(0, 63);
    w.mask_begin   = $urandom_range(0, 63);
    w.mask_end     = $urandom_range(0, 63);
    w.cr_field     = $urandom_range(0, 7);
    w.long_compare = $urandom_range(0, 1);
    w.record       = $urandom_range(0, 1);
    w.field_mask   = $urandom_range(0, 255);
    return w;
  endfunction

  // Pushes one word after a random gap and waits until it is accepted. Push
  // stays high into the next word when there is no gap.
  task automatic push_word(instr_word_t w);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    drive_w <= w;
    do @(posedge clk_i); while (full);
    sb.note_instr(w);
  endtask

  // Loads a register by clearing it with andi. and then building the value
  // with ori pieces and rotates.
  task automatic load_reg(logic [4:0] r, logic [63:0] v);
    instr_word_t w;
    w = random_instr(fxu_pkg::OP_ANDI);
    w.dest_index = r; w.src_a_index = r; w.immediate = 0;
    push_word(w);
    for (int k = 3; k >= 0; k--) begin
      w = random_instr(fxu_pkg::OP_RLDICR);
      w.dest_index = r; w.src_a_index = r; w.shift_amount = 16; w.mask_end = 47;
      w.record = 0;
      push_word(w);
      w = random_instr(fxu_pkg::OP_ORI);
      w.dest_index = r; w.src_a_index = r; w.immediate = v[16 * k +: 16];
      push_word(w);
    end
  endtask

  // Sender: a directed opening, then mostly random instructions interleaved
  // with register loads so the operands cover the interesting values.
  initial begin
    instr_word_t w;
    sb = new();
    sb.clear_state();
    push = 1'b0;
    pop = 1'b0;
    hold_off = 1'b0;
    stimulus_done = 1'b0;
    cycle_count = 0;
    drive_w = random_instr(fxu_pkg::OP_ADD);
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: corner operands, each operation once, divide by zero,
    // an unused code and long shift counts.
    load_reg(5'd1, 64'h8000_0000_0000_0001);
    load_reg(5'd2, {64{1'b1}});
    w = random_instr(fxu_pkg::OP_DIVDU); w.src_b_index = 5'd3; w.record = 1;
    w.dest_index = 5'd1; push_word(w);
    w = random_instr(fxu_pkg::OP_SRAD); w.src_a_index = 5'd1; w.src_b_index = 5'd2;
    push_word(w);
    w = random_instr(fxu_pkg::OP_ADDIC_RC); w.src_a_index = 5'd2; w.immediate = 16'hFFFF;
    push_word(w);
    w = random_instr(6'd63); push_word(w);
    w = random_instr(fxu_pkg::OP_ADDI); w.src_a_index = 5'd0; w.immediate = 16'h8000;
    push_word(w);
    w = random_instr(fxu_pkg::OP_MTCRF); w.field_mask = 8'hFF; w.src_a_index = 5'd2;
    push_word(w);
    w = random_instr(fxu_pkg::OP_MFCR); push_word(w);
    for (int op = 0; op <= fxu_pkg::OpLast; op++) push_word(random_instr(6'(op)));

    for (int i = 0; i < 340; i++) begin
      if ($urandom_range(0, 19) == 0)
        load_reg(5'($urandom_range(0, 31)), pick_value());
      else if ($urandom_range(0, 24) == 0)
        push_word(random_instr(6'($urandom_range(51, 63))));
      else
        push_word(random_instr(6'($urandom_range(0, fxu_pkg::OpLast))));
    end
    push <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Long stall: once, the receiver stops popping for a while so the input
  // queue fills and full has to hold the sender back.
  initial begin
    @(posedge rst_ni);
    repeat (300) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Receiver: pops with a random gap before each word, except during the
  // hold-off. Results are sampled at the edge that accepts them. Pop stays
  // high into the next word when there is no gap.
  initial begin
    result_word_t got;
    int           gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      if (hold_off) begin
        pop <= 1'b0;
        while (hold_off) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got.value   = result_value_o;
      got.index   = result_index_o;
      got.written = register_written_o;
      got.cr      = condition_register_o;
      got.carry   = carry_bit_o;
      sb.check_result(got);
    end
  end

  // End of run: wait for the last expected word, then a short drain so any
  // stray extra word would still be seen and flagged.
  initial begin
    @(posedge rst_ni);
    wait (stimulus_done);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
